/* design/mts_pkg.sv */
// Package for the memory test sequencer: codes, register indexes and the
// configuration struct. No dependencies.
`default_nettype none
package mts_pkg;

  localparam int unsigned MAX_WORDS_LOG2_DEF = 24;
  localparam int unsigned CFG_IDX_W          = 2;
  localparam int unsigned CFG_DATA_W         = 32;
  localparam int unsigned COUNT_W            = 25;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_WR_DONE  = 2'd1,
    OP_RD_DATA  = 2'd2,
    OP_RESERVED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_GALPAT = 2'd1,
    MODE_ADDR   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEST_MODE  = 2'd0,
    REG_BASE_ADDR  = 2'd1,
    REG_WORD_COUNT = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         test_mode;
    logic [31:0]        base_address;
    logic [COUNT_W-1:0] word_count;
  } cfg_t;

  localparam logic [1:0]         TEST_MODE_RST  = MODE_GALPAT;
  localparam logic [31:0]        BASE_ADDR_RST  = 32'd0;
  localparam logic [COUNT_W-1:0] WORD_COUNT_RST = 25'd16777216;

endpackage
`default_nettype wire

/* design/mts_req_if.sv */
// Request channel of the memory test sequencer: op and returned read data.
// Depends on nothing.
`default_nettype none
interface mts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] read_data;

  modport source (output valid, output op, output read_data, input ready);
  modport sink   (input valid, input op, input read_data, output ready);
endinterface
`default_nettype wire

/* design/mts_rsp_if.sv */
// Response channel of the memory test sequencer: memory command and check
// results. Depends on nothing.
`default_nettype none
interface mts_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] addr;
  logic [31:0] write_data;
  logic        mismatch;
  logic [31:0] mismatch_addr;
  logic [31:0] found;
  logic [31:0] expected;
  logic        failed;

  modport source (output valid, output cmd, output addr, output write_data,
                  output mismatch, output mismatch_addr, output found,
                  output expected, output failed, input ready);
  modport sink   (input valid, input cmd, input addr, input write_data,
                  input mismatch, input mismatch_addr, input found,
                  input expected, input failed, output ready);
endinterface
`default_nettype wire

/* design/mts_cfg_regs.sv */
// Configuration register file of the memory test sequencer.
// Depends on mts_pkg.
`default_nettype none
module mts_cfg_regs
  import mts_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  we_i,
  input  wire logic [CFG_IDX_W-1:0]  idx_i,
  input  wire logic [CFG_DATA_W-1:0] data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.test_mode    <= TEST_MODE_RST;
      cfg_q.base_address <= BASE_ADDR_RST;
      cfg_q.word_count   <= WORD_COUNT_RST;
    end else if (we_i) begin
      unique case (reg_idx_e'(idx_i))
        REG_TEST_MODE:  cfg_q.test_mode    <= data_i[1:0];
        REG_BASE_ADDR:  cfg_q.base_address <= data_i;
        REG_WORD_COUNT: cfg_q.word_count   <= data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* design/memory_test_sequencer_top.sv */
// Top level of the memory test sequencer: sequencing state, step logic and
// result register. Depends on mts_pkg, mts_req_if, mts_rsp_if, mts_cfg_regs.
//
// Usage: configure test_mode, base_address and word_count through the write
// port while idle, then send a start request on req_i. Each response carries
// one memory command (write, read, finished or none) plus the check of the read
// data that came with the request. Pass every write acknowledge and every
// read data word back as the next request; one request gives one response.
// The response is registered and is presented the cycle after its request is
// taken; a request is taken every cycle unless a held response stalls the
// response register. Ready stays high while the response register is empty
// or being drained, so a stalled receiver holds the response and blocks
// further requests. Reset sets the registers to their defaults, the
// sequencer to idle and clears the failed flag; no clearing pass is needed.
// A start request while a test runs aborts it and begins a new one.
`default_nettype none
module memory_test_sequencer_top
  import mts_pkg::*;
#(
  parameter int unsigned MAX_WORDS_LOG2 = MAX_WORDS_LOG2_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  mts_req_if.sink                    req_i,
  mts_rsp_if.source                  rsp_o
);

  localparam int unsigned IW = MAX_WORDS_LOG2 + 1;
  localparam int unsigned CW = (COUNT_W > IW) ? COUNT_W : IW;
  localparam int unsigned SW = (IW + 2 > 32) ? IW + 2 : 32;

  typedef enum logic [2:0] {
    PH_IDLE, PH_CLEAR, PH_GTEST, PH_GSCAN, PH_AWRITE, PH_AREAD
  } phase_e;

  cfg_t cfg;

  mts_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  phase_e      phase_q, phase_d;
  logic [1:0]  sub_q, sub_d;
  logic [IW-1:0] ti_q, ti_d, si_q, si_d;
  logic [31:0] comp_q, comp_d;
  logic [31:0] lra_q, lra_d;
  logic        failed_q, failed_d;

  logic        out_valid_q;
  logic [1:0]  cmd_q, cmd_d;
  logic [31:0] addr_q, addr_d, wdata_q, wdata_d;
  logic        mm_q, mm_d;
  logic [31:0] mma_q, mma_d, found_q, found_d, exp_q, exp_d;

  logic acc;
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign acc         = req_i.valid && req_i.ready;

  logic [CW-1:0] wc_ext, lim, cnt_w;
  logic [IW-1:0] cnt, ti_inc, si_inc;
  assign wc_ext = CW'(cfg.word_count);
  assign lim    = CW'(1) << MAX_WORDS_LOG2;
  assign cnt_w  = (wc_ext == '0) ? CW'(1) : ((wc_ext > lim) ? lim : wc_ext);
  assign cnt    = cnt_w[IW-1:0];
  assign ti_inc = ti_q + IW'(1);
  assign si_inc = si_q + IW'(1);

  logic          do_wr, do_rd, do_fin, do_chk;
  logic [IW-1:0] sel_idx;
  logic [31:0]   sel_data, chk_exp, word_addr;
  logic [SW-1:0] off;
  logic [31:0]   rdata;

  assign rdata     = req_i.read_data;
  assign off       = SW'(sel_idx) << 2;
  assign word_addr = {cfg.base_address[31:2], 2'b00} + off[31:0];

  always_comb begin
    phase_d  = phase_q;
    sub_d    = sub_q;
    ti_d     = ti_q;
    si_d     = si_q;
    comp_d   = comp_q;
    lra_d    = lra_q;
    failed_d = failed_q;
    do_wr    = 1'b0;
    do_rd    = 1'b0;
    do_fin   = 1'b0;
    do_chk   = 1'b0;
    sel_idx  = '0;
    sel_data = '0;
    chk_exp  = '0;

    unique case (op_e'(req_i.op))
      OP_START: begin
        failed_d = 1'b0;
        ti_d     = '0;
        si_d     = '0;
        sub_d    = 2'd0;
        comp_d   = '0;
        unique case (mode_e'(cfg.test_mode))
          MODE_CLEAR, MODE_GALPAT: begin
            phase_d = PH_CLEAR;
            do_wr   = 1'b1;
          end
          MODE_ADDR: begin
            phase_d = PH_AWRITE;
            do_wr   = 1'b1;
          end
          default: do_fin = 1'b1;
        endcase
      end
      OP_WR_DONE: begin
        priority if (phase_q == PH_CLEAR) begin
          ti_d = ti_inc;
          if (ti_inc >= cnt) begin
            if (cfg.test_mode == MODE_GALPAT) begin
              phase_d = PH_GTEST;
              sub_d   = 2'd0;
              ti_d    = '0;
              do_rd   = 1'b1;
            end else begin
              do_fin = 1'b1;
            end
          end else begin
            do_wr   = 1'b1;
            sel_idx = ti_inc;
          end
        end else if (phase_q == PH_GTEST && sub_q == 2'd1) begin
          phase_d = PH_GSCAN;
          sub_d   = 2'd0;
          si_d    = '0;
          do_rd   = 1'b1;
        end else if (phase_q == PH_GTEST && sub_q == 2'd3) begin
          ti_d = ti_inc;
          if (ti_inc >= cnt) begin
            do_fin = 1'b1;
          end else begin
            sub_d   = 2'd0;
            do_rd   = 1'b1;
            sel_idx = ti_inc;
          end
        end else if (phase_q == PH_AWRITE) begin
          ti_d = ti_inc;
          if (ti_inc >= cnt) begin
            phase_d = PH_AREAD;
            ti_d    = '0;
            do_rd   = 1'b1;
          end else begin
            do_wr    = 1'b1;
            sel_idx  = ti_inc;
            sel_data = 32'(ti_inc);
          end
        end else begin
        end
      end
      OP_RD_DATA: begin
        priority if (phase_q == PH_GTEST && sub_q == 2'd0) begin
          comp_d   = ~rdata;
          sub_d    = 2'd1;
          do_wr    = 1'b1;
          sel_idx  = ti_q;
          sel_data = ~rdata;
        end else if (phase_q == PH_GTEST && sub_q == 2'd2) begin
          sub_d    = 2'd3;
          do_wr    = 1'b1;
          sel_idx  = ti_q;
          sel_data = ~rdata;
        end else if (phase_q == PH_GSCAN && sub_q == 2'd0) begin
          do_chk  = 1'b1;
          chk_exp = (si_q == ti_q) ? comp_q : 32'd0;
          sub_d   = 2'd1;
          do_rd   = 1'b1;
          sel_idx = ti_q;
        end else if (phase_q == PH_GSCAN && sub_q == 2'd1) begin
          do_chk  = 1'b1;
          chk_exp = comp_q;
          si_d    = si_inc;
          do_rd   = 1'b1;
          if (si_inc >= cnt) begin
            phase_d = PH_GTEST;
            sub_d   = 2'd2;
            sel_idx = ti_q;
          end else begin
            sub_d   = 2'd0;
            sel_idx = si_inc;
          end
        end else if (phase_q == PH_AREAD) begin
          do_chk  = 1'b1;
          chk_exp = 32'(ti_q);
          ti_d    = ti_inc;
          if (ti_inc >= cnt) begin
            do_fin = 1'b1;
          end else begin
            do_rd   = 1'b1;
            sel_idx = ti_inc;
          end
        end else begin
        end
      end
      default: ;
    endcase

    cmd_d   = CMD_NONE;
    addr_d  = '0;
    wdata_d = '0;
    if (do_wr) begin
      cmd_d   = CMD_WRITE;
      addr_d  = word_addr;
      wdata_d = sel_data;
    end
    if (do_rd) begin
      cmd_d  = CMD_READ;
      addr_d = word_addr;
      lra_d  = word_addr;
    end
    if (do_fin) begin
      cmd_d   = CMD_FINISH;
      phase_d = PH_IDLE;
      sub_d   = 2'd0;
    end

    mm_d    = do_chk && (rdata != chk_exp);
    mma_d   = '0;
    found_d = '0;
    exp_d   = '0;
    if (mm_d) begin
      mma_d    = lra_q;
      found_d  = rdata;
      exp_d    = chk_exp;
      failed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      sub_q       <= 2'd0;
      ti_q        <= '0;
      si_q        <= '0;
      comp_q      <= '0;
      lra_q       <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q       <= CMD_NONE;
      addr_q      <= '0;
      wdata_q     <= '0;
      mm_q        <= 1'b0;
      mma_q       <= '0;
      found_q     <= '0;
      exp_q       <= '0;
    end else begin
      if (acc) begin
        phase_q     <= phase_d;
        sub_q       <= sub_d;
        ti_q        <= ti_d;
        si_q        <= si_d;
        comp_q      <= comp_d;
        lra_q       <= lra_d;
        failed_q    <= failed_d;
        out_valid_q <= 1'b1;
        cmd_q       <= cmd_d;
        addr_q      <= addr_d;
        wdata_q     <= wdata_d;
        mm_q        <= mm_d;
        mma_q       <= mma_d;
        found_q     <= found_d;
        exp_q       <= exp_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.cmd           = cmd_q;
  assign rsp_o.addr          = addr_q;
  assign rsp_o.write_data    = wdata_q;
  assign rsp_o.mismatch      = mm_q;
  assign rsp_o.mismatch_addr = mma_q;
  assign rsp_o.found         = found_q;
  assign rsp_o.expected      = exp_q;
  assign rsp_o.failed        = failed_q;

endmodule
`default_nettype wire
